// ===== rtl/huffman_code_bit_packer_core_defines.svh =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core_defines.svh
// Assertion macros for the bit packer checks.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define HCBP_ASSERT_IMP(LBL, ANT, CON, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |-> (CON)) \
        else $error(MSG);

// next-cycle implication, off during reset
`define HCBP_ASSERT_NXT(LBL, ANT, CON, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |=> (CON)) \
        else $error(MSG);

// next-cycle implication, also checked in reset
`define HCBP_ASSERT_NXT_RST(LBL, ANT, CON, MSG) \
    LBL: assert property (@(posedge i_clk) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

// ===== rtl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared widths, opcodes and types of the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int OP_W   = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 7;
    localparam int CNT_W  = 3;

    localparam int DEF_MAX_CODE_LEN  = 32;
    localparam int DEF_ALPHABET_SIZE = 256;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_lookup;

endpackage

// ===== rtl/hcbp_in_if.sv =====
// ----------------------------------------------------------------------------
// hcbp_in_if
// Input item channel: opcode, symbol and table entry fields.
// ----------------------------------------------------------------------------
interface hcbp_in_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, opcode, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, opcode, symbol, code_bits, code_length, output ready);
endinterface

// ===== rtl/hcbp_out_if.sv =====
// ----------------------------------------------------------------------------
// hcbp_out_if
// Output item channel: packed byte and last flag.
// ----------------------------------------------------------------------------
interface hcbp_out_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== rtl/huffman_code_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Table-driven Huffman encoder that packs code words into bytes, MSB first.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output keeps up. An encode whose code
// completes k bytes holds the burst register until all k are out, so items
// stall while such a burst drains through the single byte output (one byte
// per cycle when not stalled) or the output is stalled; items that complete
// zero or one byte otherwise stream at full rate. The first byte of an item
// passes the table read, burst and output registers in turn. The code table
// is a memory with one valid flag per entry that reset clears at once, so
// there is no clearing pass and the block is ready right out of reset.
module huffman_code_bit_packer_core #(
    parameter int MAX_CODE_LEN  = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int ALPHABET_SIZE = hcbp_pkg::DEF_ALPHABET_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcbp_in_if.sink    i_in,
    hcbp_out_if.source o_out
);
    import hcbp_pkg::*;

    logic    lk_valid;
    logic    take;
    t_lookup lk;

    hcbp_table #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_take     (take),
        .o_lk_valid (lk_valid),
        .o_lk       (lk)
    );

    hcbp_pack #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lk_valid (lk_valid),
        .i_lk       (lk),
        .o_take     (take),
        .o_out      (o_out)
    );

endmodule

// ===== rtl/hcbp_table.sv =====
// ----------------------------------------------------------------------------
// hcbp_table
// Input register stage: code table memory with per-entry valid flags,
// table writes and registered code lookup.
// ----------------------------------------------------------------------------
module hcbp_table #(
    parameter int MAX_CODE_LEN  = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int ALPHABET_SIZE = hcbp_pkg::DEF_ALPHABET_SIZE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hcbp_in_if.sink          i_in,
    input  logic             i_take,
    output logic             o_lk_valid,
    output hcbp_pkg::t_lookup o_lk
);
    import hcbp_pkg::*;

    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int ENT_W = LEN_W + CODE_W;
    localparam int CMP_W = SYM_W + 1;

    logic [ENT_W-1:0]         r_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_vld;
    logic [ENT_W-1:0]         r_rd_data;
    logic                     r_rd_vld;
    logic [OP_W-1:0]          r_op;
    logic                     r_valid;

    logic              accept;
    logic              sym_ok;
    logic              wr_en;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  wr_len;
    logic [CODE_W-1:0] wr_code;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;
    assign sym_ok     = CMP_W'(i_in.symbol) < CMP_W'(ALPHABET_SIZE);
    assign idx        = i_in.symbol[IDX_W-1:0];
    assign wr_en      = accept && (i_in.opcode == OP_WRITE) && sym_ok;

    assign wr_len  = (i_in.code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                               : i_in.code_length;
    assign wr_code = i_in.code_bits & ~({CODE_W{1'b1}} << wr_len);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[idx] <= {wr_len, wr_code};
        end
        if (accept) begin
            r_rd_data <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[idx] <= 1'b1;
            end
            if (i_in.ready) begin
                r_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_in.opcode;
            r_rd_vld <= r_vld[idx] && sym_ok;
        end
    end

    assign o_lk_valid = r_valid;
    assign o_lk.opcode = r_op;
    assign o_lk.len    = r_rd_vld ? r_rd_data[ENT_W-1 -: LEN_W] : '0;
    assign o_lk.code   = r_rd_vld ? r_rd_data[CODE_W-1:0] : '0;

endmodule

// ===== rtl/hcbp_pack.sv =====
// ----------------------------------------------------------------------------
// hcbp_pack
// Bit packer: pending bit state, byte burst register and output register.
// ----------------------------------------------------------------------------
module hcbp_pack #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_lk_valid,
    input  hcbp_pkg::t_lookup i_lk,
    output logic              o_take,
    hcbp_out_if.source        o_out
);
    import hcbp_pkg::*;

    localparam int ACC_W = PEND_W + MAX_CODE_LEN;
    localparam int TOT_W = $clog2(ACC_W + 1);
    localparam int REM_W = $clog2(ACC_W / BYTE_W + 1);

    logic [PEND_W-1:0] r_pend;
    logic [CNT_W-1:0]  r_pcnt;
    logic [ACC_W-1:0]  r_b_acc;
    logic [TOT_W-1:0]  r_b_shift;
    logic [REM_W-1:0]  r_b_rem;
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_last;

    logic [TOT_W-1:0]  clen;
    logic [ACC_W-1:0]  acc;
    logic [TOT_W-1:0]  total;
    logic [REM_W-1:0]  nby;
    logic [PEND_W-1:0] n_pend;
    logic [BYTE_W-1:0] flush_byte;
    logic              emit_go;
    logic              b_free;
    logic              do_enc;
    logic              do_flush;

    assign clen  = TOT_W'(i_lk.len);
    assign acc   = (ACC_W'(r_pend) << clen) | ACC_W'(i_lk.code);
    assign total = TOT_W'(r_pcnt) + clen;
    assign nby   = REM_W'(total >> 3);
    assign n_pend = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[CNT_W-1:0]);
    assign flush_byte = BYTE_W'({1'b0, r_pend} << (4'd8 - {1'b0, r_pcnt}));

    assign emit_go  = (r_b_rem != '0) && (!r_o_valid || o_out.ready);
    assign b_free   = (r_b_rem == '0) || ((r_b_rem == REM_W'(1)) && emit_go);
    assign o_take   = i_lk_valid && b_free;
    assign do_enc   = o_take && (i_lk.opcode == OP_ENCODE);
    assign do_flush = o_take && (i_lk.opcode == OP_FLUSH) && (r_pcnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_pcnt    <= '0;
            r_b_rem   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (do_enc) begin
                r_pend <= n_pend;
                r_pcnt <= total[CNT_W-1:0];
            end else if (do_flush) begin
                r_pend <= '0;
                r_pcnt <= '0;
            end
            if (do_enc) begin
                r_b_rem <= nby;
            end else if (do_flush) begin
                r_b_rem <= REM_W'(1);
            end else if (emit_go) begin
                r_b_rem <= r_b_rem - REM_W'(1);
            end
            if (!r_o_valid || o_out.ready) begin
                r_o_valid <= emit_go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_enc) begin
            r_b_acc   <= acc;
            r_b_shift <= total - TOT_W'(BYTE_W);
        end else if (do_flush) begin
            r_b_acc   <= ACC_W'(flush_byte);
            r_b_shift <= '0;
        end else if (emit_go) begin
            r_b_shift <= r_b_shift - TOT_W'(BYTE_W);
        end
        if (emit_go) begin
            r_o_byte <= BYTE_W'(r_b_acc >> r_b_shift);
            r_o_last <= (r_b_rem == REM_W'(1));
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.out_byte = r_o_byte;
    assign o_out.last     = r_o_last;

endmodule

// ===== rtl/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks of the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "huffman_code_bit_packer_core_defines.svh"

module hcbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    `HCBP_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "output item dropped while stalled")
    `HCBP_ASSERT_NXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_byte) && $stable(i_out_last), "output item changed while stalled")
    `HCBP_ASSERT_NXT(a_burst_gapless, i_out_valid && i_out_ready && !i_out_last, i_out_valid, "gap inside a byte burst")
    `HCBP_ASSERT_NXT_RST(a_rst_quiet, !i_rst_n, !i_out_valid, "output valid right after reset")

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);

// ===== sim/tb_huffman_code_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// tb_huffman_code_bit_packer_core
// Self-checking bench for the table-driven Huffman bit packer. A directed
// table covers empty codes, the shortest and longest codes, length
// saturation, flushes and the unused opcode, then random write/encode/flush
// traffic follows. Expected bytes come from a row's list or from a behavioral
// copy of code table and pending bits, and are compared in order on output.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RST_CYCLES  = 7;
    localparam int DIR_ROWS    = 24;
    localparam int RAND_ITEMS  = 76;
    localparam int HOLD_CYCLES = 200;
    localparam int WD_LIMIT    = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS = 10;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } t_sym_req;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_packed_byte;

    typedef struct packed {
        t_sym_req    req;
        logic        has_exp;
        logic [2:0]  exp_n;
        logic [31:0] exp_bytes;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hcbp_in_if  in_if();
    hcbp_out_if out_if();

    huffman_code_bit_packer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    logic [CODE_W-1:0] tbl_code [DEF_ALPHABET_SIZE];
    logic [LEN_W-1:0]  tbl_len  [DEF_ALPHABET_SIZE];
    logic [PEND_W-1:0] pend_bits;
    logic [CNT_W-1:0]  pend_cnt;

    t_packed_byte expected_bytes_q [$];
    int  mismatch_cnt = 0;
    int  idle_cycles  = 0;
    bit  hold_req     = 1'b0;

    function automatic void predict_packed_bytes(input t_sym_req r, input bit enq);
        logic [63:0]  acc;
        logic [63:0]  shifted;
        logic [7:0]   b8;
        int           clen;
        int           total;
        int           n;
        t_packed_byte res [4];
        n = 0;
        case (r.opcode)
            OP_WRITE: begin
                clen = (int'(r.code_length) > DEF_MAX_CODE_LEN) ? DEF_MAX_CODE_LEN
                                                                : int'(r.code_length);
                tbl_len[r.symbol]  = clen[LEN_W-1:0];
                acc                = (64'd1 << clen) - 64'd1;
                tbl_code[r.symbol] = r.code_bits & acc[CODE_W-1:0];
            end
            OP_ENCODE: begin
                clen = int'(tbl_len[r.symbol]);
                if (clen != 0) begin
                    acc   = ({57'd0, pend_bits} << clen) | {32'd0, tbl_code[r.symbol]};
                    total = int'(pend_cnt) + clen;
                    while (total >= 8) begin
                        shifted        = acc >> (total - 8);
                        res[n].data    = shifted[7:0];
                        res[n].last    = 1'b0;
                        n++;
                        total -= 8;
                    end
                    shifted   = acc & ((64'd1 << total) - 64'd1);
                    pend_bits = shifted[PEND_W-1:0];
                    pend_cnt  = total[CNT_W-1:0];
                    if (n > 0)
                        res[n-1].last = 1'b1;
                end
            end
            OP_FLUSH: begin
                if (pend_cnt != 0) begin
                    b8          = {1'b0, pend_bits};
                    res[0].data = b8 << (8 - pend_cnt);
                    res[0].last = 1'b1;
                    n           = 1;
                    pend_bits   = '0;
                    pend_cnt    = '0;
                end
            end
            default: ;
        endcase
        if (enq)
            for (int k = 0; k < n; k++)
                expected_bytes_q.insert(expected_bytes_q.size(), res[k]);
    endfunction

    function automatic t_dir_row mk_row(input logic [OP_W-1:0] op, input logic [7:0] sym,
                                        input logic [31:0] code, input logic [5:0] len,
                                        input int has_exp, input int exp_n,
                                        input logic [31:0] exp_bytes);
        t_dir_row row;
        row.req.opcode      = op;
        row.req.symbol      = sym;
        row.req.code_bits   = code;
        row.req.code_length = len;
        row.has_exp         = (has_exp != 0);
        row.exp_n           = exp_n[2:0];
        row.exp_bytes       = exp_bytes;
        return row;
    endfunction

    function automatic int pick_src_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_sym(input t_sym_req r, input bit has_exp, input int exp_n,
                            input logic [31:0] exp_bytes, input int gap);
        t_packed_byte b;
        in_if.valid       <= 1'b1;
        in_if.opcode      <= r.opcode;
        in_if.symbol      <= r.symbol;
        in_if.code_bits   <= r.code_bits;
        in_if.code_length <= r.code_length;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_packed_bytes(r, !has_exp);
        if (has_exp)
            for (int k = 0; k < exp_n; k++) begin
                b.data = exp_bytes[31 - 8*k -: 8];
                b.last = (k == exp_n - 1);
                expected_bytes_q.insert(expected_bytes_q.size(), b);
            end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // output compare
    always @(posedge i_clk) begin
        t_packed_byte got;
        t_packed_byte want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.data = out_if.out_byte;
            got.last = out_if.last;
            if (expected_bytes_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected byte %02h last %0d", got.data, got.last);
            end else begin
                want = expected_bytes_q.pop_front();
                if (got.data !== want.data || got.last !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("byte mismatch: expected %02h last %0d, got %02h last %0d",
                                 want.data, want.last, got.data, got.last);
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", idle_cycles);
                $display("huffman_code_bit_packer_core verification failed");
                $finish;
            end
        end
    end

    initial begin : sink_pacing
        int  gap;
        int  calm;
        int  r;
        bit  hold_done;
        calm      = 0;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (calm > 0) begin
                calm--;
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    calm = $urandom_range(20, 60);
                end else if (r <= 4) begin
                    gap = $urandom_range(1, 3);
                    out_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end else if (r == 5) begin
                    gap = $urandom_range(10, 40);
                    out_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end else begin
                    out_if.ready <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row     dir_tab [DIR_ROWS];
        t_sym_req     req;
        logic [7:0]   sym_pool [$];
        int           counted;
        int           r;
        int           gap;

        for (int s = 0; s < DEF_ALPHABET_SIZE; s++) begin
            tbl_code[s] = '0;
            tbl_len[s]  = '0;
        end
        pend_bits = '0;
        pend_cnt  = '0;

        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.opcode      <= OP_WRITE;
        in_if.symbol      <= '0;
        in_if.code_bits   <= '0;
        in_if.code_length <= '0;

        // empty code, empty flush, shortest/longest codes, saturation, unused op
        dir_tab[0]  = mk_row(OP_ENCODE, 8'h00, 32'h0,         6'd0,  1, 0, 32'h0);
        dir_tab[1]  = mk_row(OP_FLUSH,  8'h00, 32'h0,         6'd0,  1, 0, 32'h0);
        dir_tab[2]  = mk_row(OP_WRITE,  8'h41, 32'h0000_00A5, 6'd8,  1, 0, 32'h0);
        dir_tab[3]  = mk_row(OP_ENCODE, 8'h41, 32'h0,         6'd0,  1, 1, 32'hA500_0000);
        dir_tab[4]  = mk_row(OP_WRITE,  8'hFF, 32'hFFFF_FFFF, 6'd32, 1, 0, 32'h0);
        dir_tab[5]  = mk_row(OP_ENCODE, 8'hFF, 32'h0,         6'd0,  1, 4, 32'hFFFF_FFFF);
        dir_tab[6]  = mk_row(OP_WRITE,  8'h00, 32'h0,         6'd1,  1, 0, 32'h0);
        dir_tab[7]  = mk_row(OP_ENCODE, 8'h00, 32'h0,         6'd0,  0, 0, 32'h0);
        dir_tab[8]  = mk_row(OP_WRITE,  8'h01, 32'h0000_0005, 6'd3,  1, 0, 32'h0);
        dir_tab[9]  = mk_row(OP_ENCODE, 8'h01, 32'h0,         6'd0,  0, 0, 32'h0);
        dir_tab[10] = mk_row(OP_FLUSH,  8'h00, 32'h0,         6'd0,  1, 1, 32'h5000_0000);
        dir_tab[11] = mk_row(OP_WRITE,  8'h02, 32'hDEAD_BEEF, 6'd63, 1, 0, 32'h0);
        dir_tab[12] = mk_row(OP_ENCODE, 8'h02, 32'h0,         6'd0,  1, 4, 32'hDEAD_BEEF);
        dir_tab[13] = mk_row(OP_WRITE,  8'h03, 32'hFFFF_FFFF, 6'd5,  1, 0, 32'h0);
        dir_tab[14] = mk_row(OP_ENCODE, 8'h03, 32'h0,         6'd0,  0, 0, 32'h0);
        dir_tab[15] = mk_row(OP_ENCODE, 8'h01, 32'h0,         6'd0,  1, 1, 32'hFD00_0000);
        dir_tab[16] = mk_row(OP_UNUSED, 8'h41, 32'h1234_5678, 6'd8,  1, 0, 32'h0);
        dir_tab[17] = mk_row(OP_WRITE,  8'h41, 32'hFFFF_FFFF, 6'd0,  1, 0, 32'h0);
        dir_tab[18] = mk_row(OP_ENCODE, 8'h41, 32'h0,         6'd0,  1, 0, 32'h0);
        // build up seven pending bits, then a full-length code
        dir_tab[19] = mk_row(OP_ENCODE, 8'h03, 32'h0,         6'd0,  0, 0, 32'h0);
        dir_tab[20] = mk_row(OP_ENCODE, 8'h00, 32'h0,         6'd0,  0, 0, 32'h0);
        dir_tab[21] = mk_row(OP_ENCODE, 8'h00, 32'h0,         6'd0,  0, 0, 32'h0);
        dir_tab[22] = mk_row(OP_ENCODE, 8'hFF, 32'h0,         6'd0,  0, 0, 32'h0);
        dir_tab[23] = mk_row(OP_FLUSH,  8'h00, 32'h0,         6'd0,  0, 0, 32'h0);

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_sym(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].exp_n,
                     dir_tab[i].exp_bytes, pick_src_gap());

        sym_pool.insert(sym_pool.size(), 8'hFF);
        sym_pool.insert(sym_pool.size(), 8'h02);
        counted = 0;
        while (counted < RAND_ITEMS) begin
            req.symbol    = SYM_W'($urandom_range(0, 255));
            req.code_bits = $urandom;
            r = $urandom_range(0, 19);
            if (r == 0)
                req.code_length = 6'd0;
            else if (r == 1)
                req.code_length = LEN_W'($urandom_range(33, 63));
            else if (r <= 5)
                req.code_length = LEN_W'($urandom_range(13, 32));
            else
                req.code_length = LEN_W'($urandom_range(1, 12));
            r = $urandom_range(0, 99);
            if (r < 22) begin
                req.opcode = OP_WRITE;
                if (req.code_length != 0)
                    sym_pool.insert(sym_pool.size(), req.symbol);
            end else if (r < 78) begin
                req.opcode = OP_ENCODE;
                if ($urandom_range(0, 6) != 0)
                    req.symbol = sym_pool[$urandom_range(0, sym_pool.size() - 1)];
            end else if (r < 94) begin
                req.opcode = OP_FLUSH;
            end else begin
                req.opcode = OP_UNUSED;
            end
            if (req.opcode != OP_UNUSED)
                counted++;
            if (counted == 40)
                hold_req = 1'b1;
            // back-to-back while the output is held off
            gap = (counted >= 40 && counted < 70) ? 0 : pick_src_gap();
            send_sym(req, 1'b0, 0, 32'h0, gap);
        end
        in_if.valid <= 1'b0;

        while (expected_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && expected_bytes_q.size() == 0)
            $display("huffman_code_bit_packer_core verification clean");
        else
            $display("huffman_code_bit_packer_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hcbp_pkg.sv
rtl/hcbp_in_if.sv
rtl/hcbp_out_if.sv
rtl/hcbp_table.sv
rtl/hcbp_pack.sv
rtl/huffman_code_bit_packer_core.sv
rtl/hcbp_checker.sv
sim/tb_huffman_code_bit_packer_core.sv
